/* rtl/bfsk_gz_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BFSK Goertzel demodulator package
// Shared constants, configuration register indexes and beat types.
// ----------------------------------------------------------------------------
package bfsk_gz_pkg;

    localparam int SAMPLE_WIDTH          = 16;
    localparam int COEF_WIDTH            = 18;
    localparam int SPB_WIDTH             = 13;
    localparam int CFG_IDX_WIDTH         = 2;
    localparam int CFG_DATA_WIDTH        = 18;
    localparam int FRAC_BITS             = 15;
    localparam int BITS_PER_BYTE         = 8;
    localparam int POW_WIDTH             = 64;
    localparam int ACC_WIDTH_DEF         = 40;
    localparam int MAX_SAMPLES_PER_BIT_DEF = 4096;
    localparam int SPB_RESET             = 40;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SAMPLES_PER_BIT = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_COEF_ZERO       = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_COEF_ONE        = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           end_of_signal;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] bits_decided;
    } t_out_beat;

endpackage
`default_nettype wire

/* rtl/bfsk_gz_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BFSK Goertzel shared multiplier
// Signed W by W multiply in two half-width passes with a registered product.
// ----------------------------------------------------------------------------
module bfsk_gz_mul #(
    parameter int W = 40
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [W-1:0]   i_a,
    input  wire logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0]      o_prod,
    output logic                       o_done
);

    localparam int LoW = W / 2;
    localparam int HiW = W - LoW;
    localparam int BW  = HiW + 1;
    localparam int PW  = 2 * W;
    localparam int MW  = W + BW;

    logic signed [W-1:0]  r_a;
    logic        [W-1:0]  r_b;
    logic                 r_busy;
    logic        [1:0]    r_step;
    logic signed [MW-1:0] r_prod;
    logic signed [PW-1:0] r_acc;
    logic                 r_done;

    logic signed [BW-1:0] w_op_b;
    logic signed [MW-1:0] n_prod;
    logic signed [PW-1:0] w_prod_x;

    assign w_op_b = (r_step == 2'd0) ? $signed({{(BW-LoW){1'b0}}, r_b[LoW-1:0]})
                                     : $signed({r_b[W-1], r_b[W-1:LoW]});
    assign n_prod   = r_a * w_op_b;
    assign w_prod_x = PW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            if (r_step != 2'd2) begin
                r_prod <= n_prod;
            end
            if (r_step == 2'd1) begin
                r_acc <= w_prod_x;
            end else if (r_step == 2'd2) begin
                r_acc <= r_acc + (w_prod_x <<< LoW);
            end
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule
`default_nettype wire

/* rtl/bfsk_goertzel_demodulator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BFSK Goertzel demodulator core
// Two Goertzel recursions on one shared multiplier decide FSK bits and pack
// them into bytes, least significant bit first.
//
// One audio sample is taken per input beat. The core is busy while it works
// on a sample and raises o_in_ready again when it is done. A sample that
// closes a bit period takes longer, since both tone powers then need four
// more products each. Every product goes through the one multiplier, which
// needs two half-width passes per product; that unit sets the rate.
// A result beat is offered on the output channel after the eighth bit of a
// byte, or on a sample marked end of signal when a byte has been started.
// The result sits in an output register; while the receiver stalls the core
// still takes the next sample and only waits if that sample produces a
// further result. Configuration writes are taken whenever i_cfg_we is high
// and are meant for idle periods. Reset returns all recursion and byte state
// to zero, the period to 40 samples and both coefficients to zero.
// ----------------------------------------------------------------------------
module bfsk_goertzel_demodulator_core #(
    parameter int ACC_WIDTH           = bfsk_gz_pkg::ACC_WIDTH_DEF,
    parameter int MAX_SAMPLES_PER_BIT = bfsk_gz_pkg::MAX_SAMPLES_PER_BIT_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire bfsk_gz_pkg::t_in_beat                   i_in_data,
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output bfsk_gz_pkg::t_out_beat                       o_out_data,
    input  wire logic                                    i_cfg_we,
    input  wire logic [bfsk_gz_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  wire logic [bfsk_gz_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    import bfsk_gz_pkg::*;

    localparam int W   = ACC_WIDTH;
    localparam int PW  = 2 * W;
    localparam int EW  = (PW > POW_WIDTH + 2) ? PW : POW_WIDTH + 2;
    localparam int CW  = $clog2(MAX_SAMPLES_PER_BIT + 1);
    localparam int PCW = (CW > SPB_WIDTH) ? CW : SPB_WIDTH;

    localparam logic signed [EW-1:0] A_MAX = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] P_MAX =
        {{(EW-POW_WIDTH+1){1'b0}}, {(POW_WIDTH-1){1'b1}}};

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_STEP_START = 4'd1;
    localparam logic [3:0] S_STEP_WAIT  = 4'd2;
    localparam logic [3:0] S_STEP_ADD   = 4'd3;
    localparam logic [3:0] S_STEP_SUB   = 4'd4;
    localparam logic [3:0] S_PW_START   = 4'd5;
    localparam logic [3:0] S_PW_WAIT    = 4'd6;
    localparam logic [3:0] S_PW_ACC     = 4'd7;
    localparam logic [3:0] S_PW_NEXT    = 4'd8;
    localparam logic [3:0] S_FINISH     = 4'd9;

    localparam logic [1:0] OP_COEF     = 2'd0;
    localparam logic [1:0] OP_PREV_SQ  = 2'd1;
    localparam logic [1:0] OP_PREV2_SQ = 2'd2;
    localparam logic [1:0] OP_CROSS    = 2'd3;

    logic [SPB_WIDTH-1:0]         r_spb;
    logic signed [COEF_WIDTH-1:0] r_coef0;
    logic signed [COEF_WIDTH-1:0] r_coef1;

    logic [3:0]                   r_state;
    logic                         r_tone;
    logic [1:0]                   r_op;
    logic signed [W-1:0]          r_z1;
    logic signed [W-1:0]          r_z2;
    logic signed [W-1:0]          r_o1;
    logic signed [W-1:0]          r_o2;
    logic [CW-1:0]                r_cnt;
    logic [2:0]                   r_bitpos;
    logic [7:0]                   r_byte;
    logic                         r_started;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic                         r_eos;
    logic signed [W-1:0]          r_t;
    logic signed [W-1:0]          r_s;
    logic signed [POW_WIDTH-1:0]  r_q;
    logic signed [POW_WIDTH-1:0]  r_pow;
    logic signed [POW_WIDTH-1:0]  r_p0;
    logic                         r_emit;
    logic [7:0]                   r_emit_byte;
    logic                         r_out_valid;
    t_out_beat                    r_out;

    logic signed [W-1:0]          w_coef_w;
    logic signed [W-1:0]          w_p1;
    logic signed [W-1:0]          w_p2;
    logic signed [W-1:0]          w_mul_a;
    logic signed [W-1:0]          w_mul_b;
    logic                         w_mul_start;
    logic signed [PW-1:0]         w_prod;
    logic                         w_mul_done;
    logic signed [EW-1:0]         w_sh;
    logic signed [EW-1:0]         w_t_sat;
    logic signed [EW-1:0]         w_q_sat;
    logic signed [EW-1:0]         w_add_sat;
    logic signed [EW-1:0]         w_sub_sat;
    logic signed [EW-1:0]         w_pacc_add;
    logic signed [EW-1:0]         w_pacc_sub;
    logic [CW-1:0]                w_period;
    logic [PCW-1:0]               w_spb_x;
    logic                         w_bit;
    logic [7:0]                   n_byte;
    logic                         w_want;
    logic                         w_out_free;
    logic                         w_out_load;
    logic                         w_in_fire;

    function automatic logic signed [EW-1:0] f_sat(input logic signed [EW-1:0] v,
                                                   input logic signed [EW-1:0] hi);
        logic signed [EW-1:0] lo;
        lo = ~hi;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    assign w_coef_w = r_tone ? W'(r_coef1) : W'(r_coef0);
    assign w_p1     = r_tone ? r_o1 : r_z1;
    assign w_p2     = r_tone ? r_o2 : r_z2;

    always_comb begin
        w_mul_a = w_coef_w;
        w_mul_b = w_p1;
        if (r_state == S_PW_START) begin
            case (r_op)
                OP_COEF: begin
                    w_mul_a = w_coef_w;
                    w_mul_b = w_p1;
                end
                OP_PREV_SQ: begin
                    w_mul_a = w_p1;
                    w_mul_b = w_p1;
                end
                OP_PREV2_SQ: begin
                    w_mul_a = w_p2;
                    w_mul_b = w_p2;
                end
                default: begin
                    w_mul_a = r_t;
                    w_mul_b = w_p2;
                end
            endcase
        end
    end

    assign w_mul_start = (r_state == S_STEP_START) || (r_state == S_PW_START);

    bfsk_gz_mul #(
        .W (W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_prod  (w_prod),
        .o_done  (w_mul_done)
    );

    assign w_sh       = EW'(w_prod) >>> FRAC_BITS;
    assign w_t_sat    = f_sat(w_sh, A_MAX);
    assign w_q_sat    = f_sat(w_sh, P_MAX);
    assign w_add_sat  = f_sat(EW'(r_x) + EW'(r_t), A_MAX);
    assign w_sub_sat  = f_sat(EW'(r_s) - EW'(w_p2), A_MAX);
    assign w_pacc_add = f_sat(EW'(r_pow) + EW'(r_q), P_MAX);
    assign w_pacc_sub = f_sat(EW'(r_pow) - EW'(r_q), P_MAX);

    assign w_spb_x = PCW'(r_spb);
    always_comb begin
        if (r_spb == '0) begin
            w_period = CW'(1);
        end else if (w_spb_x > PCW'(MAX_SAMPLES_PER_BIT)) begin
            w_period = CW'(MAX_SAMPLES_PER_BIT);
        end else begin
            w_period = w_spb_x[CW-1:0];
        end
    end

    assign w_bit      = r_pow > r_p0;
    assign n_byte     = r_byte | (8'(w_bit) << r_bitpos);
    assign w_want     = r_emit || (r_eos && r_started);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = (r_state == S_FINISH) && w_want && w_out_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb   <= SPB_WIDTH'(SPB_RESET);
            r_coef0 <= '0;
            r_coef1 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLES_PER_BIT: r_spb   <= i_cfg_data[SPB_WIDTH-1:0];
                CFG_COEF_ZERO:       r_coef0 <= $signed(i_cfg_data[COEF_WIDTH-1:0]);
                CFG_COEF_ONE:        r_coef1 <= $signed(i_cfg_data[COEF_WIDTH-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tone      <= 1'b0;
            r_op        <= OP_COEF;
            r_z1        <= '0;
            r_z2        <= '0;
            r_o1        <= '0;
            r_o2        <= '0;
            r_cnt       <= '0;
            r_bitpos    <= '0;
            r_byte      <= '0;
            r_started   <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_x       <= i_in_data.sample;
                        r_eos     <= i_in_data.end_of_signal;
                        r_cnt     <= r_cnt + CW'(1);
                        r_started <= 1'b1;
                        r_tone    <= 1'b0;
                        r_state   <= S_STEP_START;
                    end
                end
                S_STEP_START: begin
                    r_state <= S_STEP_WAIT;
                end
                S_STEP_WAIT: begin
                    if (w_mul_done) begin
                        r_t     <= w_t_sat[W-1:0];
                        r_state <= S_STEP_ADD;
                    end
                end
                S_STEP_ADD: begin
                    r_s     <= w_add_sat[W-1:0];
                    r_state <= S_STEP_SUB;
                end
                S_STEP_SUB: begin
                    if (r_tone) begin
                        r_o2 <= r_o1;
                        r_o1 <= w_sub_sat[W-1:0];
                        r_tone <= 1'b0;
                        r_op   <= OP_COEF;
                        r_state <= (r_cnt >= w_period) ? S_PW_START : S_FINISH;
                    end else begin
                        r_z2    <= r_z1;
                        r_z1    <= w_sub_sat[W-1:0];
                        r_tone  <= 1'b1;
                        r_state <= S_STEP_START;
                    end
                end
                S_PW_START: begin
                    r_state <= S_PW_WAIT;
                end
                S_PW_WAIT: begin
                    if (w_mul_done) begin
                        if (r_op == OP_COEF) begin
                            r_t <= w_t_sat[W-1:0];
                        end
                        r_q     <= w_q_sat[POW_WIDTH-1:0];
                        r_state <= S_PW_ACC;
                    end
                end
                S_PW_ACC: begin
                    case (r_op)
                        OP_COEF:     r_pow <= r_pow;
                        OP_PREV_SQ:  r_pow <= r_q;
                        OP_PREV2_SQ: r_pow <= w_pacc_add[POW_WIDTH-1:0];
                        default:     r_pow <= w_pacc_sub[POW_WIDTH-1:0];
                    endcase
                    if (r_op == OP_CROSS) begin
                        r_state <= S_PW_NEXT;
                    end else begin
                        r_op    <= r_op + 2'd1;
                        r_state <= S_PW_START;
                    end
                end
                S_PW_NEXT: begin
                    if (!r_tone) begin
                        r_p0    <= r_pow;
                        r_tone  <= 1'b1;
                        r_op    <= OP_COEF;
                        r_state <= S_PW_START;
                    end else begin
                        r_z1  <= '0;
                        r_z2  <= '0;
                        r_o1  <= '0;
                        r_o2  <= '0;
                        r_cnt <= '0;
                        if (r_bitpos == 3'(BITS_PER_BYTE - 1)) begin
                            r_emit      <= 1'b1;
                            r_emit_byte <= n_byte;
                            r_byte      <= '0;
                            r_bitpos    <= '0;
                            r_started   <= 1'b0;
                        end else begin
                            r_byte   <= n_byte;
                            r_bitpos <= r_bitpos + 3'd1;
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!w_want || w_out_free) begin
                        if (w_want) begin
                            r_out.data_byte    <= r_emit ? r_emit_byte : r_byte;
                            r_out.bits_decided <= r_emit ? 4'(BITS_PER_BYTE)
                                                         : {1'b0, r_bitpos};
                        end
                        if (r_eos) begin
                            r_z1      <= '0;
                            r_z2      <= '0;
                            r_o1      <= '0;
                            r_o2      <= '0;
                            r_cnt     <= '0;
                            r_bitpos  <= '0;
                            r_byte    <= '0;
                            r_started <= 1'b0;
                        end
                        r_emit  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_STEP_WAIT || r_state == S_PW_WAIT))
        else $error("multiplier result arrived outside a wait state");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.bits_decided <= 4'(BITS_PER_BYTE)))
        else $error("bit count of a result beat exceeds a byte");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt < CW'(MAX_SAMPLES_PER_BIT)))
        else $error("sample count of a bit period out of range while idle");

    a_full_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_emit) |-> (r_bitpos == '0 && !r_started))
        else $error("full byte pending while byte state not cleared");

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BFSK Goertzel demodulator testbench
// Sample beats go through short directed runs and eight random phases of
// tone, noise and rail messages under four idling patterns. A fixed-point
// Goertzel predictor in the bench works out every byte beat, and the output
// channel is checked against it field by field.
// ----------------------------------------------------------------------------
module tb;
    import bfsk_gz_pkg::*;

    localparam int     ACC_W        = ACC_WIDTH_DEF;
    localparam int     MAX_SPB      = MAX_SAMPLES_PER_BIT_DEF;
    localparam int     DRAIN_CYCLES = 100;
    localparam int     STALL_LIMIT  = 4000;
    localparam int     PHASE_ITEMS  = 90;
    localparam longint ACC_MAX      = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam longint ACC_MIN      = -ACC_MAX - 64'sd1;
    localparam longint WIDE_MAX     = 64'sh7fff_ffff_ffff_ffff;
    localparam longint WIDE_MIN     = -WIDE_MAX - 64'sd1;
    localparam real    TWO_PI       = 6.283185307179586;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    t_in_beat                  i_in_data   = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    t_out_beat                 o_out_data;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx   = CFG_SAMPLES_PER_BIT;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data  = '0;

    t_in_beat  sample_queue[$];
    t_out_beat bytes_due[$];
    logic      in_taken       = 1'b0;
    int        idle_cycles    = 0;
    int        mismatch_count = 0;
    int        tx_idle_pct    = 0;
    int        rx_stall_pct   = 0;
    int        phase_items    = 0;
    real       tone_phase     = 0.0;
    real       freq_zero      = 0.125;
    real       freq_one       = 0.25;

    logic [SPB_WIDTH-1:0] period_cfg    = SPB_WIDTH'(SPB_RESET);
    longint               coef_zero_cfg = 0;
    longint               coef_one_cfg  = 0;

    longint     zero_prev      = 0;
    longint     zero_prev2     = 0;
    longint     one_prev       = 0;
    longint     one_prev2      = 0;
    int         samples_in_bit = 0;
    int         bit_pos        = 0;
    logic [7:0] byte_bits      = '0;
    logic       byte_open      = 1'b0;

    bfsk_goertzel_demodulator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint q15_product(longint a, longint b, longint lo, longint hi);
        logic signed [127:0] p;
        p = a * b;
        p = p >>> FRAC_BITS;
        if (p > hi) return hi;
        if (p < lo) return lo;
        return longint'(p);
    endfunction

    function automatic longint clamp_sum(longint a, longint b, logic subtract,
                                         longint lo, longint hi);
        logic signed [65:0] s;
        s = subtract ? a - b : a + b;
        if (s > hi) return hi;
        if (s < lo) return lo;
        return longint'(s);
    endfunction

    task automatic goertzel_step(inout longint prev, inout longint prev2,
                                 input longint coef, input longint x);
        longint t;
        longint s;
        t = q15_product(coef, prev, ACC_MIN, ACC_MAX);
        s = clamp_sum(x, t, 1'b0, ACC_MIN, ACC_MAX);
        s = clamp_sum(s, prev2, 1'b1, ACC_MIN, ACC_MAX);
        prev2 = prev;
        prev  = s;
    endtask

    function automatic longint tone_power(longint prev, longint prev2, longint coef);
        longint t;
        longint p;
        t = q15_product(coef, prev, ACC_MIN, ACC_MAX);
        p = q15_product(prev, prev, WIDE_MIN, WIDE_MAX);
        p = clamp_sum(p, q15_product(prev2, prev2, WIDE_MIN, WIDE_MAX), 1'b0,
                      WIDE_MIN, WIDE_MAX);
        return clamp_sum(p, q15_product(t, prev2, WIDE_MIN, WIDE_MAX), 1'b1,
                         WIDE_MIN, WIDE_MAX);
    endfunction

    task automatic demod_sample(input t_in_beat beat);
        int        period;
        logic      emitted;
        t_out_beat res;
        period  = int'(period_cfg);
        emitted = 1'b0;
        if (period < 1) period = 1;
        if (period > MAX_SPB) period = MAX_SPB;
        goertzel_step(zero_prev, zero_prev2, coef_zero_cfg, longint'($signed(beat.sample)));
        goertzel_step(one_prev, one_prev2, coef_one_cfg, longint'($signed(beat.sample)));
        byte_open = 1'b1;
        samples_in_bit++;
        if (samples_in_bit >= period) begin
            if (tone_power(one_prev, one_prev2, coef_one_cfg) >
                tone_power(zero_prev, zero_prev2, coef_zero_cfg)) begin
                byte_bits[bit_pos] = 1'b1;
            end
            bit_pos++;
            zero_prev      = 0;
            zero_prev2     = 0;
            one_prev       = 0;
            one_prev2      = 0;
            samples_in_bit = 0;
            if (bit_pos >= BITS_PER_BYTE) begin
                res.data_byte    = byte_bits;
                res.bits_decided = 4'(BITS_PER_BYTE);
                bytes_due = {bytes_due, res};
                emitted   = 1'b1;
                bit_pos   = 0;
                byte_bits = '0;
                byte_open = 1'b0;
            end
        end
        if (beat.end_of_signal) begin
            if (byte_open && !emitted) begin
                res.data_byte    = byte_bits;
                res.bits_decided = 4'(bit_pos);
                bytes_due = {bytes_due, res};
            end
            zero_prev      = 0;
            zero_prev2     = 0;
            one_prev       = 0;
            one_prev2      = 0;
            samples_in_bit = 0;
            bit_pos        = 0;
            byte_bits      = '0;
            byte_open      = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_beat due;
        logic      in_fire;
        logic      out_fire;
        in_fire  = i_in_valid && o_in_ready;
        out_fire = o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (out_fire) begin
                if (bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte beat data %h bits %0d",
                                              o_out_data.data_byte, o_out_data.bits_decided));
                end else begin
                    due = bytes_due.pop_front();
                    if (o_out_data.data_byte !== due.data_byte) begin
                        report_mismatch($sformatf("data_byte %h, expected %h",
                                                  o_out_data.data_byte, due.data_byte));
                    end
                    if (o_out_data.bits_decided !== due.bits_decided) begin
                        report_mismatch($sformatf("bits_decided %0d, expected %0d",
                                                  o_out_data.bits_decided, due.bits_decided));
                    end
                end
            end
            if (in_fire) begin
                demod_sample(sample_queue.pop_front());
            end
            idle_cycles <= (in_fire || out_fire) ? 0 : idle_cycles + 1;
        end
        in_taken <= i_rst_n && in_fire;
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (i_rst_n && sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= sample_queue[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_SAMPLES_PER_BIT: period_cfg = value[SPB_WIDTH-1:0];
            CFG_COEF_ZERO:       coef_zero_cfg = longint'($signed(value));
            CFG_COEF_ONE:        coef_one_cfg = longint'($signed(value));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int period, input logic [CFG_DATA_WIDTH-1:0] c_zero,
                              input logic [CFG_DATA_WIDTH-1:0] c_one);
        write_reg(CFG_SAMPLES_PER_BIT, CFG_DATA_WIDTH'(period));
        write_reg(CFG_COEF_ZERO, c_zero);
        write_reg(CFG_COEF_ONE, c_one);
    endtask

    task automatic queue_sample(input int value, input logic eos);
        t_in_beat beat;
        beat.sample        = value[SAMPLE_WIDTH-1:0];
        beat.end_of_signal = eos;
        sample_queue = {sample_queue, beat};
        phase_items++;
    endtask

    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (sample_queue.size() != 0 || i_in_valid || bytes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One message is a run of bit periods closed by an end-of-signal beat;
    // a broken message has a random length that need not be a whole number of bits.
    task automatic queue_message(input int period);
        int   total;
        int   style;
        int   amp;
        int   value;
        logic one_bit;
        total   = period * $urandom_range(1, 40 / period + 2);
        style   = $urandom_range(9);
        amp     = $urandom_range(32767);
        one_bit = 1'b0;
        if ($urandom_range(9) < 2) total = $urandom_range(1, total + period - 1);
        for (int k = 0; k < total; k++) begin
            if (k % period == 0) one_bit = $urandom_range(1);
            if (style < 7) begin
                value = $rtoi(amp * $cos(tone_phase));
                tone_phase = tone_phase + TWO_PI * (one_bit ? freq_one : freq_zero);
            end else if (style < 9) begin
                value = $urandom_range(65535) - 32768;
            end else begin
                value = one_bit ? 32767 : -32768;
            end
            queue_sample(value, k == total - 1);
        end
    endtask

    initial begin : stimulus
        int period;
        int c_zero;
        int c_one;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_config(0, 18'h1ffff, 18'h20000);
        @(posedge i_clk);
        #1;
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(-1, 1'b0);
        queue_sample(1, 1'b0);
        queue_sample(21845, 1'b0);
        queue_sample(-21846, 1'b0);
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(-32768, 1'b0);
        queue_sample(12345, 1'b1);
        drain();

        set_config(8191, 18'h10000, 18'h30000);
        @(posedge i_clk);
        #1;
        queue_sample(32767, 1'b0);
        queue_sample(-32768, 1'b1);
        drain();

        set_config(MAX_SPB, 18'd46341, 18'd0);
        @(posedge i_clk);
        #1;
        for (int k = 0; k < 6; k++) begin
            queue_sample((k % 2 == 1) ? 0 : ((k % 4 == 0) ? 32767 : -32768), 1'b0);
        end
        drain();
        write_reg(CFG_SAMPLES_PER_BIT, CFG_DATA_WIDTH'(3));
        @(posedge i_clk);
        #1;
        queue_sample(-1, 1'b0);
        queue_sample(7, 1'b1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) period = 1;
            else if (ph == 6) period = $urandom_range(9, 16);
            else period = $urandom_range(2, 6);
            freq_zero = $urandom_range(1, 15) / 32.0;
            freq_one  = $urandom_range(1, 15) / 32.0;
            if (freq_one == freq_zero) freq_one = 0.5 - freq_zero + 1.0 / 32.0;
            if (ph == 2 || ph == 5) begin
                c_zero = $urandom_range(262143);
                c_one  = $urandom_range(262143);
            end else begin
                c_zero = $rtoi(2.0 * $cos(TWO_PI * freq_zero) * 32768.0);
                c_one  = $rtoi(2.0 * $cos(TWO_PI * freq_one) * 32768.0);
            end
            set_config(period, CFG_DATA_WIDTH'(c_zero), CFG_DATA_WIDTH'(c_one));
            case (ph % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 76;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 76;
                end
                default: begin
                    tx_idle_pct  = 18;
                    rx_stall_pct = 18;
                end
            endcase
            @(posedge i_clk);
            #1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) queue_message(period);
            drain();
        end

        foreach (bytes_due[k]) begin
            report_mismatch($sformatf("byte beat never arrived: data %h bits %0d",
                                      bytes_due[k].data_byte, bytes_due[k].bits_decided));
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bfsk_gz_pkg.sv
rtl/bfsk_gz_mul.sv
rtl/bfsk_goertzel_demodulator_core.sv
verif/tb.sv
